@@ hdl/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/fbfla_pkg.sv @@
// shared constants and codes of the block pool allocator
package fbfla_pkg;

  // pool geometry
  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int HEAD_W     = $clog2(NUM_BLOCKS + 1);

  // configuration register widths
  // (0x1FFFF + 3) / 4 = 0x8000 needs one bit more than BYTES_W - 2
  localparam int BIU_W   = 11;
  localparam int BYTES_W = 17;
  localparam int WORDS_W = BYTES_W - 1;
  localparam int CFG_W   = BYTES_W;

  // result widths
  localparam int OFS_W  = 24;
  localparam int PROD_W = BLK_W + WORDS_W;
  localparam int ST_W   = 2;

  // packed beat widths
  localparam int IN_DATA_W  = ((BLK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((BLK_W + OFS_W + 7) / 8) * 8;

  // request kinds
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic REG_BLOCKS_IN_USE = 1'b0;
  localparam logic REG_BLOCK_BYTES   = 1'b1;

  // reset values
  localparam logic [BIU_W-1:0]   BIU_RESET   = 11'd1024;
  localparam logic [WORDS_W-1:0] WORDS_RESET = 16'd16;

endpackage

@@ hdl/fixed_block_free_list_allocator_unit.sv @@
// Pool allocator of equal-size blocks with a LIFO free list held in a link memory.
// A request on the in_ channel is either an allocate or a release, and every request
// gives exactly one result beat. The accepting edge loads the holding register, which
// moves into the output register once that is free or drained by out_tready, after
// which in_tready rises again. An allocate that pops a previously released block
// takes the next head from the registered link-memory read in the S_POP state while
// the holding register moves on, so it costs no more than any other request. The
// output register lets the next request be taken while a result waits at the out_
// side; a further request then waits until out_tready drains it. The word offset
// is block number times (block_bytes + 3) / 4, saturated at 24 bits. No clearing pass
// is needed after reset: a counter hands out never-used blocks in ascending order.
module fixed_block_free_list_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fbfla_pkg::IN_DATA_W-1:0]   in_tdata,   // [9:0] block_number, rest zero
  input  logic [0:0]                        in_tuser,   // [0] operation
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fbfla_pkg::OUT_DATA_W-1:0]  out_tdata,  // [9:0] granted_block,
                                                        // [33:10] word_offset, rest zero
  output logic [fbfla_pkg::ST_W-1:0]        out_tuser,  // [1:0] status
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [fbfla_pkg::CFG_W-1:0]       cfg_data
);
  import fbfla_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  // state and configuration
  logic               state_r;
  logic [HEAD_W-1:0]  free_head_r;
  logic [HEAD_W-1:0]  never_used_r;
  logic [BIU_W-1:0]   biu_r;
  logic [WORDS_W-1:0] words_r;

  // link memory
  logic [HEAD_W-1:0]  link_mem [NUM_BLOCKS];
  logic [HEAD_W-1:0]  link_q_r;

  // holding and output registers
  logic               res_valid_r;
  logic [ST_W-1:0]    res_status_r;
  logic [BLK_W-1:0]   res_blk_r;
  logic [PROD_W-1:0]  res_prod_r;
  logic               out_valid_r;
  logic [ST_W-1:0]    out_status_r;
  logic [BLK_W-1:0]   out_blk_r;
  logic [OFS_W-1:0]   out_ofs_r;

  // request decode
  logic               in_fire;
  logic               op;
  logic [BLK_W-1:0]   num;
  logic [HEAD_W-1:0]  pool_size;
  logic               head_valid;
  logic               bump_ok;
  logic               rel_ok;
  logic [BLK_W-1:0]   grant;
  logic [ST_W-1:0]    status;
  logic               out_load;
  logic [OFS_W-1:0]   ofs_sat;
  logic [BYTES_W:0]   bytes_rnd;

  assign in_tready  = (state_r == S_IDLE) && !res_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign op         = in_tuser[0];
  assign num        = in_tdata[BLK_W-1:0];
  assign pool_size  = (biu_r > BIU_W'(NUM_BLOCKS)) ? HEAD_W'(NUM_BLOCKS) : HEAD_W'(biu_r);
  assign head_valid = (free_head_r < HEAD_W'(NUM_BLOCKS));
  assign bump_ok    = (never_used_r < pool_size);
  assign rel_ok     = ({1'b0, num} < pool_size);
  assign cfg_ready  = 1'b1;
  assign bytes_rnd  = {1'b0, cfg_data} + (BYTES_W+1)'(3);

  // pick the granted block and the status
  always_comb begin
    grant  = '0;
    status = ST_OK;
    if (op == OP_ALLOC) begin
      if (head_valid) begin
        grant = free_head_r[BLK_W-1:0];
      end else if (bump_ok) begin
        grant = never_used_r[BLK_W-1:0];
      end else begin
        status = ST_EMPTY;
      end
    end else if (!rel_ok) begin
      status = ST_RANGE;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r   <= BIU_RESET;
      words_r <= WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index[0])
        REG_BLOCKS_IN_USE: biu_r   <= cfg_data[BIU_W-1:0];
        REG_BLOCK_BYTES:   words_r <= bytes_rnd[BYTES_W:2];
        default:           ;
      endcase
    end
  end

  // link memory: push writes the old head, read follows the head
  always_ff @(posedge clk) begin
    if (in_fire && op == OP_RELEASE && rel_ok) begin
      link_mem[num] <= free_head_r;
    end
    link_q_r <= link_mem[free_head_r[BLK_W-1:0]];
  end

  // free list control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= HEAD_W'(NUM_BLOCKS);
      never_used_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (op == OP_ALLOC) begin
              if (head_valid) begin
                state_r <= S_POP;
              end else if (bump_ok) begin
                never_used_r <= never_used_r + HEAD_W'(1);
              end
            end else if (rel_ok) begin
              free_head_r <= {1'b0, num};
            end
          end
        end
        S_POP: begin
          free_head_r <= link_q_r;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // holding register with the raw product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_fire) begin
      res_valid_r <= 1'b1;
    end else if (out_load) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_status_r <= status;
      res_blk_r    <= grant;
      res_prod_r   <= PROD_W'(grant) * PROD_W'(words_r);
    end
  end

  // saturate the offset and load the output register
  assign out_load = res_valid_r && (!out_valid_r || out_tready);
  assign ofs_sat  = (|res_prod_r[PROD_W-1:OFS_W]) ? {OFS_W{1'b1}} : res_prod_r[OFS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_blk_r    <= res_blk_r;
      out_ofs_r    <= ofs_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W - BLK_W - OFS_W){1'b0}}, out_ofs_r, out_blk_r};

endmodule

@@ hdl/fbfla_checker.sv @@
// port-level checker for the block pool allocator and its bind
`include "assert_macros.svh"

module fbfla_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [fbfla_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [fbfla_pkg::ST_W-1:0]        out_tuser
);
  import fbfla_pkg::*;

  // a waiting result beat is not withdrawn
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // only the three defined status codes appear
  `ASSERT_IMPLY(a_status_code, clk, rst_n, out_tvalid, out_tuser <= ST_RANGE)

  // a failed beat carries no block and no offset
  `ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_tvalid && out_tuser != ST_OK, out_tdata == '0)

  // one request at a time: an accepted beat closes the input in the next cycle
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind fixed_block_free_list_allocator_unit fbfla_checker u_fbfla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
